// File: sv/bcsm_pkg.sv
// Shared types, codes and helpers for the bitmap compressed sparse map.
// Used by bcsm_cell and bitmap_compressed_sparse_map; depends on nothing.
`default_nettype none

package bcsm_pkg;

    // Default configuration
    localparam int DEF_CAPACITY    = 8;
    localparam int DEF_NUM_IDS     = 64;
    localparam int DEF_VALUE_WIDTH = 32;

    // Fixed field widths of the ports
    localparam int OP_W     = 2;
    localparam int ID_W     = 6;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 6;
    localparam int COUNT_W  = 7;

    // Operation codes
    localparam logic [OP_W-1:0] OP_FIND   = 2'd0;
    localparam logic [OP_W-1:0] OP_SET    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ABSENT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_REPLACED = 2'd3;

    // Broadcast control for the row of value cells
    typedef struct packed {
        logic               insert;
        logic               remove;
        logic               write;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] count;
    } cell_ctl_t;

    // Count the set bits of a 64-bit word: per-byte counts, then an adder tree
    function automatic logic [COUNT_W-1:0] popcount64(input logic [63:0] word);
        logic [3:0] byte_cnt [8];
        logic [4:0] pair_cnt [4];
        logic [5:0] quad_cnt [2];
        for (int b = 0; b < 8; b++)
        begin
            byte_cnt[b] = '0;
            for (int i = 0; i < 8; i++)
            begin
                byte_cnt[b] = byte_cnt[b] + 4'(word[8*b+i]);
            end
        end
        for (int p = 0; p < 4; p++)
        begin
            pair_cnt[p] = 5'(byte_cnt[2*p]) + 5'(byte_cnt[2*p+1]);
        end
        for (int q = 0; q < 2; q++)
        begin
            quad_cnt[q] = 6'(pair_cnt[2*q]) + 6'(pair_cnt[2*q+1]);
        end
        return COUNT_W'(quad_cnt[0]) + COUNT_W'(quad_cnt[1]);
    endfunction

endpackage

`default_nettype wire

// File: sv/bcsm_cell.sv
// One value cell of the compact store: holds one entry and takes its
// neighbor's value on insert or remove. Depends on bcsm_pkg.
`default_nettype none

module bcsm_cell
    import bcsm_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    parameter int CELL_INDEX  = 0
)
(
    input  wire logic                   clk,
    input  wire cell_ctl_t              ctl,
    input  wire logic [VALUE_WIDTH-1:0] left_value,
    input  wire logic [VALUE_WIDTH-1:0] right_value,
    input  wire logic [VALUE_WIDTH-1:0] wdata,
    output logic      [VALUE_WIDTH-1:0] value
);

    localparam logic [COUNT_W-1:0] IDX = COUNT_W'(CELL_INDEX);

    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;
    logic [COUNT_W-1:0]     slot_ext;

    assign slot_ext = COUNT_W'(ctl.slot);

    // Pick the new entry: own slot, neighbor below or neighbor above
    always_comb
    begin
        value_next = value_reg;
        if (ctl.insert)
        begin
            if (IDX == slot_ext)
            begin
                value_next = wdata;
            end
            else if (IDX > slot_ext && IDX <= ctl.count)
            begin
                value_next = left_value;
            end
        end
        else if (ctl.remove)
        begin
            if (IDX >= slot_ext && (IDX + COUNT_W'(1)) < ctl.count)
            begin
                value_next = right_value;
            end
        end
        else if (ctl.write)
        begin
            if (IDX == slot_ext)
            begin
                value_next = wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

// File: sv/bitmap_compressed_sparse_map.sv
// Top level of the bitmap compressed sparse map: presence bitmap, slot
// lookup stage and the row of bcsm_cell value cells. Depends on bcsm_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries operation, item_id and
//   write_value; output channel (out_valid/out_ready) carries status,
//   read_value, slot and entry_count, one result per input transaction.
//   A transaction is looked up in the cycle it is accepted: the slot is the
//   popcount of the presence bits below item_id and is registered with the
//   request. When the output register can take it, the request updates
//   the bitmap, the entry count and the cell row (insert moves later cells
//   up, remove moves them down) and loads the output register.
//   The result passes through the lookup stage and then the output register.
//   No new transaction is accepted while one waits in the lookup stage, so
//   each lookup sees the bitmap left by the previous transaction.
//   Reset empties the map (bitmap and count cleared); the cell contents
//   are not cleared and are only read below the entry count.
//   When the receiver stalls, the result holds in the output register, one
//   more request may be accepted and waits in the lookup stage; further
//   input is held off until the output register drains.
`default_nettype none

module bitmap_compressed_sparse_map
    import bcsm_pkg::*;
#(
    parameter int CAPACITY    = DEF_CAPACITY,
    parameter int NUM_IDS     = DEF_NUM_IDS,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic        [OP_W-1:0]     operation,
    input  wire logic        [ID_W-1:0]     item_id,
    input  wire logic signed [DATA_W-1:0]   write_value,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic             [STATUS_W-1:0] status,
    output logic signed      [DATA_W-1:0]   read_value,
    output logic             [SLOT_W-1:0]   slot,
    output logic             [COUNT_W-1:0]  entry_count
);

    localparam logic [COUNT_W-1:0] CAP_C = COUNT_W'(CAPACITY);

    // Map state
    logic [NUM_IDS-1:0]  presence_reg;
    logic [NUM_IDS-1:0]  presence_next;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;

    // Lookup stage
    logic                   stage_valid_reg;
    logic [OP_W-1:0]        stage_op_reg;
    logic [ID_W-1:0]        stage_id_reg;
    logic                   stage_id_ok_reg;
    logic                   stage_present_reg;
    logic [SLOT_W-1:0]      stage_slot_reg;
    logic [VALUE_WIDTH-1:0] stage_value_reg;

    // Output register
    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [STATUS_W-1:0]   status_next;
    logic [DATA_W-1:0]     read_value_reg;
    logic [DATA_W-1:0]     read_value_next;
    logic [SLOT_W-1:0]     slot_reg;
    logic [COUNT_W-1:0]    entry_count_reg;

    // Lookup signals
    logic                   accept;
    logic                   commit;
    logic [63:0]            presence_wide;
    logic [63:0]            id_bit;
    logic [63:0]            below_mask;
    logic                   id_ok;
    logic                   id_present;
    logic [SLOT_W-1:0]      lookup_slot;
    logic signed [63:0]     write_wide;

    // Cell row
    cell_ctl_t              ctl;
    logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
    logic [VALUE_WIDTH-1:0] hit_value;
    logic signed [63:0]     hit_wide;
    logic [63:0]            stage_bit;
    logic                   slot_in_store;

    assign in_ready = !stage_valid_reg;
    assign accept   = in_valid && in_ready;
    assign commit   = stage_valid_reg && (!out_valid_reg || out_ready);

    // Look up presence and slot of the incoming id
    assign presence_wide = 64'(presence_reg);
    assign id_bit        = 64'(1) << item_id;
    assign below_mask    = id_bit - 64'(1);
    assign id_ok         = 7'(item_id) < 7'(NUM_IDS);
    assign id_present    = id_ok && ((presence_wide & id_bit) != 64'(0));
    assign lookup_slot   = SLOT_W'(popcount64(presence_wide & below_mask));
    assign write_wide    = 64'(write_value);

    // Hold the request in the lookup stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (commit)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_op_reg      <= operation;
            stage_id_reg      <= item_id;
            stage_id_ok_reg   <= id_ok;
            stage_present_reg <= id_present;
            stage_slot_reg    <= lookup_slot;
            stage_value_reg   <= write_wide[VALUE_WIDTH-1:0];
        end
    end

    // Select the entry at the looked-up slot
    always_comb
    begin
        hit_value = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            if (stage_slot_reg == SLOT_W'(k))
            begin
                hit_value = cell_value[k];
            end
        end
    end

    assign hit_wide      = 64'(signed'(hit_value));
    assign stage_bit     = 64'(1) << stage_id_reg;
    assign slot_in_store = COUNT_W'(stage_slot_reg) < CAP_C;

    // Decide the outcome and the state update of the staged request
    always_comb
    begin
        status_next     = ST_OK;
        read_value_next = '0;
        presence_next   = presence_reg;
        count_next      = count_reg;
        ctl.insert      = 1'b0;
        ctl.remove      = 1'b0;
        ctl.write       = 1'b0;
        ctl.slot        = stage_slot_reg;
        ctl.count       = count_reg;
        case (stage_op_reg)
            OP_FIND:
            begin
                if (stage_present_reg && slot_in_store)
                begin
                    read_value_next = hit_wide[DATA_W-1:0];
                end
                else
                begin
                    status_next = ST_ABSENT;
                end
            end
            OP_SET:
            begin
                if (!stage_id_ok_reg)
                begin
                    status_next = ST_ABSENT;
                end
                else if (stage_present_reg)
                begin
                    ctl.write   = commit;
                    status_next = ST_REPLACED;
                end
                else if (count_reg >= CAP_C || !slot_in_store)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctl.insert    = commit;
                    presence_next = presence_reg | stage_bit[NUM_IDS-1:0];
                    count_next    = count_reg + COUNT_W'(1);
                end
            end
            OP_REMOVE:
            begin
                if (stage_present_reg)
                begin
                    ctl.remove    = commit;
                    presence_next = presence_reg & ~stage_bit[NUM_IDS-1:0];
                    count_next    = count_reg - COUNT_W'(1);
                end
                else
                begin
                    status_next = ST_ABSENT;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // Advance map state on commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            presence_reg <= '0;
            count_reg    <= '0;
        end
        else if (commit)
        begin
            presence_reg <= presence_next;
            count_reg    <= count_next;
        end
    end

    // Row of value cells, each linked to its neighbors
    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        logic [VALUE_WIDTH-1:0] left_in;
        logic [VALUE_WIDTH-1:0] right_in;

        if (k == 0)
        begin : g_first
            assign left_in = '0;
        end
        else
        begin : g_left
            assign left_in = cell_value[k-1];
        end

        if (k == CAPACITY - 1)
        begin : g_last
            assign right_in = '0;
        end
        else
        begin : g_right
            assign right_in = cell_value[k+1];
        end

        bcsm_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .CELL_INDEX  (k)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .left_value  (left_in),
            .right_value (right_in),
            .wdata       (stage_value_reg),
            .value       (cell_value[k])
        );
    end

    // Load the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            status_reg      <= status_next;
            read_value_reg  <= read_value_next;
            slot_reg        <= stage_slot_reg;
            entry_count_reg <= count_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign read_value  = read_value_reg;
    assign slot        = slot_reg;
    assign entry_count = entry_count_reg;

`ifndef NO_ASSERTIONS
    // Entry count tracks the bitmap
    a_count_matches_bitmap: assert property (@(posedge clk) disable iff (!rst_n)
        COUNT_W'($countones(presence_reg)) == count_reg)
        else $error("entry count differs from bitmap population");

    // Store never overfills
    a_count_in_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("entry count exceeds capacity");

    // A new result comes only from a staged request
    a_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(stage_valid_reg))
        else $error("result appeared without a staged request");

    // A rejected set reports a full store
    a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_FULL) |-> entry_count_reg == CAP_C)
        else $error("full status with free capacity");
`endif

endmodule

`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for bitmap_compressed_sparse_map: a directed table
// followed by random find/set/remove/unused-code traffic with random stalls on both sides.
// Depends on bcsm_pkg and the block's top level; results are predicted in-line.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bcsm_pkg::*;

    localparam int CAPACITY      = DEF_CAPACITY;
    localparam int NUM_DIRECTED  = 25;
    localparam int RANDOM_BLOCKS = 17;
    localparam int BLOCK_ITEMS   = 50;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_MAX    = 10;

    // Operation code the block leaves unused
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] value;
        logic [SLOT_W-1:0]        slot;
        logic [COUNT_W-1:0]       count;
    } map_result_t;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [ID_W-1:0]          id;
        logic [DATA_W-1:0]        wv;
        logic                     typed;
        logic [STATUS_W-1:0]      e_status;
        logic [DATA_W-1:0]        e_value;
        logic [SLOT_W-1:0]        e_slot;
        logic [COUNT_W-1:0]       e_count;
    } stim_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic [OP_W-1:0]            operation;
    logic [ID_W-1:0]            item_id;
    logic signed [DATA_W-1:0]   write_value;
    logic                       out_valid;
    logic                       out_ready;
    logic [STATUS_W-1:0]        status;
    logic signed [DATA_W-1:0]   read_value;
    logic [SLOT_W-1:0]          slot;
    logic [COUNT_W-1:0]         entry_count;

    // Shadow copy of the map
    logic [63:0]                map_bits;
    logic [DATA_W-1:0]          value_row [CAPACITY];

    map_result_t                pending_results [$];
    stim_row_t                  directed_rows [NUM_DIRECTED];
    int                         mismatch_count;
    int                         cycle_count;
    bit                         no_gaps;

    bitmap_compressed_sparse_map uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .item_id     (item_id),
        .write_value (write_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .read_value  (read_value),
        .slot        (slot),
        .entry_count (entry_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Apply one operation to the shadow map and return the result it gives
    function automatic map_result_t apply_map_op(input logic [OP_W-1:0] op,
                                                 input logic [ID_W-1:0] id,
                                                 input logic [DATA_W-1:0] wv);
        map_result_t res;
        logic [63:0] below;
        int          pos;
        int          held;
        res   = '0;
        below = (64'd1 << id) - 64'd1;
        pos   = $countones(map_bits & below);
        held  = $countones(map_bits);
        res.slot = pos[SLOT_W-1:0];
        case (op)
            OP_FIND:
            begin
                if (map_bits[id])
                    res.value = value_row[pos];
                else
                    res.status = ST_ABSENT;
            end
            OP_SET:
            begin
                if (map_bits[id])
                begin
                    value_row[pos] = wv;
                    res.status = ST_REPLACED;
                end
                else if (held >= CAPACITY)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    // open the slot by moving later entries up
                    for (int k = held; k > pos; k--)
                        value_row[k] = value_row[k-1];
                    value_row[pos] = wv;
                    map_bits[id] = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (map_bits[id])
                begin
                    // close the gap by moving later entries down
                    for (int k = pos; k + 1 < held; k++)
                        value_row[k] = value_row[k+1];
                    map_bits[id] = 1'b0;
                end
                else
                begin
                    res.status = ST_ABSENT;
                end
            end
            default: ;
        endcase
        res.count = COUNT_W'($countones(map_bits));
        return res;
    endfunction

    // Pick a sender gap: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 8);
        return $urandom_range(15, 30);
    endfunction

    // Present one transaction, hold it until accepted, then queue its result
    task automatic send_op(input stim_row_t row);
        int          gap;
        map_result_t res;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= row.op;
        item_id     <= row.id;
        write_value <= row.wv;
        do
            @(posedge clk);
        while (!in_ready);
        res = apply_map_op(row.op, row.id, row.wv);
        if (row.typed)
            res = '{row.e_status, row.e_value, row.e_slot, row.e_count};
        pending_results = {pending_results, res};
    endtask

    // Build a random transaction with the given operation mix
    function automatic stim_row_t random_row(input int set_pct, input int remove_pct);
        stim_row_t row;
        int        r;
        int        pick;
        int        held;
        row  = '0;
        r    = $urandom_range(0, 99);
        if (r < 5)
            row.op = OP_UNUSED;
        else if (r < 5 + set_pct)
            row.op = OP_SET;
        else if (r < 5 + set_pct + remove_pct)
            row.op = OP_REMOVE;
        else
            row.op = OP_FIND;
        held = $countones(map_bits);
        row.id = ID_W'($urandom_range(0, 63));
        // favor ids that are present so finds and removes hit
        if (held > 0 && $urandom_range(0, 99) < 45)
        begin
            pick = $urandom_range(0, held - 1);
            for (int i = 0; i < 64; i++)
            begin
                if (map_bits[i])
                begin
                    if (pick == 0)
                        row.id = ID_W'(i);
                    pick--;
                end
            end
        end
        r = $urandom_range(0, 99);
        if (r < 3)
            row.wv = 32'h8000_0000;
        else if (r < 6)
            row.wv = 32'h7FFF_FFFF;
        else if (r < 8)
            row.wv = 32'h0000_0000;
        else if (r < 10)
            row.wv = 32'hFFFF_FFFF;
        else
            row.wv = $urandom;
        return row;
    endfunction

    // Stall the receiver at random: long ready runs, short and long stalls
    initial
    begin
        int r;
        int len;
        logic level;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                len = $urandom_range(1, 20);
                level = 1'b1;
            end
            else if (r < 92)
            begin
                len = $urandom_range(1, 3);
                level = 1'b0;
            end
            else
            begin
                len = $urandom_range(10, 40);
                level = 1'b0;
            end
            @(negedge clk);
            out_ready <= level;
            repeat (len - 1) @(negedge clk);
        end
    end

    // Check each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        map_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result: status=%0d value=%h slot=%0d count=%0d",
                             status, read_value, slot, entry_count);
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status || read_value !== want.value ||
                    slot !== want.slot || entry_count !== want.count)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display({"mismatch: status %0d/%0d value %h/%h ",
                                  "slot %0d/%0d count %0d/%0d (exp/act)"},
                                 want.status, status, want.value, read_value,
                                 want.slot, slot, want.count, entry_count);
                end
            end
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    initial
    begin
        int set_pct;
        int remove_pct;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        operation      = OP_FIND;
        item_id        = '0;
        write_value    = '0;
        map_bits       = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        no_gaps        = 1'b0;
        for (int i = 0; i < CAPACITY; i++)
            value_row[i] = '0;

        // Directed rows: empty map, extremes, fill to full, replace, removes
        directed_rows = '{
            '{OP_FIND,    6'd0,  32'h0000_0000, 1'b1, ST_ABSENT,   32'h0000_0000, 6'd0, 7'd0},
            '{OP_REMOVE,  6'd63, 32'h0000_0000, 1'b1, ST_ABSENT,   32'h0000_0000, 6'd0, 7'd0},
            '{OP_UNUSED,  6'd5,  32'h1234_5678, 1'b1, ST_OK,       32'h0000_0000, 6'd0, 7'd0},
            '{OP_SET,     6'd63, 32'h7FFF_FFFF, 1'b1, ST_OK,       32'h0000_0000, 6'd0, 7'd1},
            '{OP_SET,     6'd0,  32'h8000_0000, 1'b1, ST_OK,       32'h0000_0000, 6'd0, 7'd2},
            '{OP_FIND,    6'd63, 32'h0000_0000, 1'b1, ST_OK,       32'h7FFF_FFFF, 6'd1, 7'd2},
            '{OP_FIND,    6'd0,  32'hFFFF_FFFF, 1'b1, ST_OK,       32'h8000_0000, 6'd0, 7'd2},
            '{OP_SET,     6'd0,  32'hFFFF_FFFF, 1'b1, ST_REPLACED, 32'h0000_0000, 6'd0, 7'd2},
            '{OP_FIND,    6'd0,  32'h0000_0000, 1'b0, ST_OK,       32'h0,         6'd0, 7'd0},
            '{OP_SET,     6'd32, 32'h0000_0000, 1'b0, ST_OK,       32'h0,         6'd0, 7'd0},
            '{OP_SET,     6'd31, 32'hA5A5_A5A5, 1'b0, ST_OK,       32'h0,         6'd0, 7'd0},
            '{OP_SET,     6'd1,  32'h5A5A_5A5A, 1'b0, ST_OK,       32'h0,         6'd0, 7'd0},
            '{OP_SET,     6'd62, 32'h0000_0001, 1'b0, ST_OK,       32'h0,         6'd0, 7'd0},
            '{OP_SET,     6'd10, 32'hDEAD_BEEF, 1'b0, ST_OK,       32'h0,         6'd0, 7'd0},
            '{OP_SET,     6'd21, 32'h0F0F_0F0F, 1'b0, ST_OK,       32'h0,         6'd0, 7'd0},
            '{OP_SET,     6'd42, 32'h1111_1111, 1'b1, ST_FULL,     32'h0000_0000, 6'd6, 7'd8},
            '{OP_SET,     6'd31, 32'h2222_2222, 1'b0, ST_OK,       32'h0,         6'd0, 7'd0},
            '{OP_FIND,    6'd42, 32'h0000_0000, 1'b0, ST_OK,       32'h0,         6'd0, 7'd0},
            '{OP_REMOVE,  6'd0,  32'h0000_0000, 1'b0, ST_OK,       32'h0,         6'd0, 7'd0},
            '{OP_REMOVE,  6'd63, 32'h0000_0000, 1'b0, ST_OK,       32'h0,         6'd0, 7'd0},
            '{OP_REMOVE,  6'd21, 32'h0000_0000, 1'b0, ST_OK,       32'h0,         6'd0, 7'd0},
            '{OP_FIND,    6'd62, 32'h0000_0000, 1'b0, ST_OK,       32'h0,         6'd0, 7'd0},
            '{OP_UNUSED,  6'd63, 32'hFFFF_FFFF, 1'b0, ST_OK,       32'h0,         6'd0, 7'd0},
            '{OP_REMOVE,  6'd21, 32'h0000_0000, 1'b0, ST_OK,       32'h0,         6'd0, 7'd0},
            '{OP_SET,     6'd63, 32'h8000_0000, 1'b0, ST_OK,       32'h0,         6'd0, 7'd0}
        };

        // Hold reset, then release at a falling edge
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_op(directed_rows[i]);

        // Random traffic in blocks, each with its own mix and gap mode
        for (int b = 0; b < RANDOM_BLOCKS; b++)
        begin
            set_pct    = $urandom_range(25, 60);
            remove_pct = $urandom_range(10, 35);
            no_gaps    = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < BLOCK_ITEMS; i++)
                send_op(random_row(set_pct, remove_pct));
        end

        @(negedge clk);
        in_valid <= 1'b0;

        // Drain outstanding results, then watch for stray ones
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
